>>> hw/rtl/slsk_pkg.sv
// ----------------------------------------------------------------------------
// slsk_pkg
// Shared types and constants for the searchable LIFO stack.
// ----------------------------------------------------------------------------
package slsk_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_CNT_W   = 7;

    typedef enum logic [2:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_PEEK   = 3'd2,
        KIND_SEARCH = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2
    } t_err;

    // per-cell control, broadcast from the stack controller
    typedef struct packed {
        logic load;   // a request is accepted this cycle
        logic push;   // shift words toward the bottom
        logic pop;    // shift words toward the top
        logic cmp;    // compare this cell against the key
    } t_cell_ctl;

endpackage

>>> hw/rtl/slsk_cell.sv
// ----------------------------------------------------------------------------
// slsk_cell
// One stack slot: holds a word, shifts with its neighbors on push and pop,
// and registers a key match for the search reduction.
// ----------------------------------------------------------------------------
module slsk_cell
    import slsk_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [WORD_W-1:0] i_prev_word,
    input  logic signed [WORD_W-1:0] i_next_word,
    input  logic signed [WORD_W-1:0] i_key,
    output logic signed [WORD_W-1:0] o_word,
    output logic                     o_hit
);

    logic signed [WORD_W-1:0] r_word;
    logic                     r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (i_ctl.push) begin
                r_word <= i_prev_word;
            end else if (i_ctl.pop) begin
                r_word <= i_next_word;
            end
            r_hit <= i_ctl.cmp & (r_word == i_key);
        end
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule

>>> hw/rtl/searchable_lifo_stack.sv
// ----------------------------------------------------------------------------
// searchable_lifo_stack
// LIFO stack of signed words built as a shifting row of cells, with search.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one request (i_kind,
// i_push_value, i_search_key). Output channel: o_out_valid / i_out_stall
// carry one result per request (top value, count, sum, key found, empty,
// error code).
// A request updates the cell row in the cycle it is accepted; at the same edge
// every occupied cell compares its word with the key, and every cell registers
// a hit bit. Once the output register is free, the hit bits are ORed and the
// result moves from the pending stage into the output register.
// The pending stage holds one request at a time, so no new request is taken
// until the previous one has moved on. A new request is taken while a finished
// result still waits in the output register.
// When the receiver stalls, the output register holds its result and the
// pending stage fills; o_in_stall then stays high until the output drains.
// Reset (i_rst_n low, synchronous) empties the stack, zeroes the sum and
// drops all pending results. Stored words are not cleared.
// ----------------------------------------------------------------------------
module searchable_lifo_stack
    import slsk_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_kind,
    input  logic signed [WORD_W-1:0]    i_push_value,
    input  logic signed [WORD_W-1:0]    i_search_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [WORD_W-1:0]    o_top_value,
    output logic [OUT_CNT_W-1:0]        o_entry_count,
    output logic signed [WORD_W-1:0]    o_element_sum,
    output logic                        o_key_found,
    output logic                        o_is_empty,
    output logic [1:0]                  o_error_code
);

    logic signed [WORD_W-1:0] w_word [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]   w_hit;
    t_cell_ctl                w_ctl  [STACK_DEPTH];

    logic                     r_count_unused;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [WORD_W-1:0] r_sum, n_sum;

    logic                     r_pend_valid;
    logic                     r_pend_search, n_pend_search;
    logic signed [WORD_W-1:0] r_pend_top, n_pend_top;
    t_err                     r_pend_err, n_pend_err;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_top;
    logic [OUT_CNT_W-1:0]     r_out_count;
    logic signed [WORD_W-1:0] r_out_sum;
    logic                     r_out_found;
    logic                     r_out_empty;
    t_err                     r_out_err;

    logic                     w_accept;
    logic                     w_move;
    logic                     w_push;
    logic                     w_pop;
    logic                     w_nonzero;
    logic                     w_full;
    logic signed [WORD_W-1:0] w_top_cur;
    logic [CNT_W+OUT_CNT_W-1:0] w_count_ext;

    assign w_accept  = i_in_valid & ~o_in_stall;
    assign w_move    = r_pend_valid & (~r_out_valid | ~i_out_stall);
    assign w_nonzero = (r_count != '0);
    assign w_full    = (r_count == CNT_W'(STACK_DEPTH));
    assign w_top_cur = w_nonzero ? w_word[0] : '0;

    always_comb begin
        n_count       = r_count;
        n_sum         = r_sum;
        n_pend_top    = w_top_cur;
        n_pend_err    = ERR_NONE;
        n_pend_search = 1'b0;
        w_push        = 1'b0;
        w_pop         = 1'b0;
        case (t_kind'(i_kind))
            KIND_PUSH: begin
                if (w_full) begin
                    n_pend_err = ERR_OVER;
                end else begin
                    w_push     = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    n_sum      = r_sum + i_push_value;
                    n_pend_top = i_push_value;
                end
            end
            KIND_POP: begin
                if (!w_nonzero) begin
                    n_pend_err = ERR_UNDER;
                end else begin
                    w_pop   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_sum   = r_sum - w_word[0];
                end
            end
            KIND_PEEK: begin
                if (!w_nonzero) begin
                    n_pend_err = ERR_UNDER;
                end
            end
            KIND_SEARCH: begin
                n_pend_search = 1'b1;
            end
            KIND_CLEAR: begin
                n_count    = '0;
                n_sum      = '0;
                n_pend_top = '0;
            end
            default: begin
            end
        endcase
    end

    // cell 0 is the top of the stack; push shifts toward the bottom
    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] w_prev;
            logic signed [WORD_W-1:0] w_next;

            if (g == 0) begin : g_first
                assign w_prev = i_push_value;
            end else begin : g_mid
                assign w_prev = w_word[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign w_next = w_word[g];
            end else begin : g_body
                assign w_next = w_word[g+1];
            end

            // count is the number of occupied slots: slot g from top is occupied
            // when its depth index g is below the count
            assign w_ctl[g].load = w_accept;
            assign w_ctl[g].push = w_push;
            assign w_ctl[g].pop  = w_pop;
            assign w_ctl[g].cmp  = n_pend_search & (CNT_W'(g) < r_count);

            slsk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[g]),
                .i_prev_word (w_prev),
                .i_next_word (w_next),
                .i_key       (i_search_key),
                .o_word      (w_word[g]),
                .o_hit       (w_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count      <= n_count;
                r_sum        <= n_sum;
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign r_count_unused = 1'b0;
    assign w_count_ext    = {{OUT_CNT_W{r_count_unused}}, r_count};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_top    <= n_pend_top;
            r_pend_err    <= n_pend_err;
            r_pend_search <= n_pend_search;
        end
        if (w_move) begin
            r_out_top   <= r_pend_top;
            r_out_count <= w_count_ext[OUT_CNT_W-1:0];
            r_out_sum   <= r_sum;
            r_out_found <= r_pend_search & (|w_hit);
            r_out_empty <= ~w_nonzero;
            r_out_err   <= r_pend_err;
        end
    end

    assign o_in_stall    = r_pend_valid;
    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_entry_count = r_out_count;
    assign o_element_sum = r_out_sum;
    assign o_key_found   = r_out_found;
    assign o_is_empty    = r_out_empty;
    assign o_error_code  = r_out_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("pending stage not held after request");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_pop |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not lower the count");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_push |=> w_word[0] == $past(i_push_value))
        else $error("pushed word not at top");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && !r_pend_search |=> !o_key_found)
        else $error("key found on a non-search request");

endmodule
